@@ hdl/tvn_pkg.sv @@
// Package for the terrain vertex normal generator.
// Field widths, pipeline depths and shared types; no dependencies.
package tvn_pkg;

  localparam int IDX_W    = 10;  // row / column width
  localparam int CFG_GW   = 11;  // grid size register width
  localparam int CFG_TW   = 7;   // tile size register width
  localparam int HGT_W    = 16;  // height width, signed Q7.8
  localparam int DIFF_W   = HGT_W + 1;
  localparam int ABS_W    = HGT_W;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int SUM_W    = SQ_W + 1;
  localparam int LIM_W    = SQ_W + 28;
  localparam int ACC_W    = LIM_W + 6;
  localparam int NRM_W    = 15;  // magnitude of one normal component
  localparam int SQRT_STEPS = NRM_W;
  localparam int TEX_W    = IDX_W + 8;
  localparam int DIV_STEPS  = TEX_W;
  localparam int LANES    = 3;   // x, y, z

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // Limit for the y component: 256^2 << 28
  localparam logic [LIM_W-1:0] LIM_Y = LIM_W'(1) << 44;
  localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(65536);

  // APB register indexes
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_TILE = 2'd2;

  typedef struct packed {
    logic signed [HGT_W-1:0] hc;
    logic                    sx;
    logic                    sz;
  } side_t;

endpackage

@@ hdl/tvn_front.sv @@
// Front stages: differences, border test, squares and the normalizer sum.
// Uses tvn_pkg.
module tvn_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          v_i,
  input  logic [tvn_pkg::IDX_W-1:0]     row_i,
  input  logic [tvn_pkg::IDX_W-1:0]     col_i,
  input  logic signed [tvn_pkg::HGT_W-1:0] hc_i,
  input  logic signed [tvn_pkg::HGT_W-1:0] hl_i,
  input  logic signed [tvn_pkg::HGT_W-1:0] hr_i,
  input  logic signed [tvn_pkg::HGT_W-1:0] ha_i,
  input  logic signed [tvn_pkg::HGT_W-1:0] hb_i,
  input  logic [tvn_pkg::CFG_GW-1:0]    cols_i,
  input  logic [tvn_pkg::CFG_GW-1:0]    rows_i,
  output logic                          v_o,
  output logic [tvn_pkg::SUM_W-1:0]     s_o,
  output logic [tvn_pkg::LIM_W-1:0]     lim_o [tvn_pkg::LANES],
  output tvn_pkg::side_t                side_o
);
  import tvn_pkg::*;

  logic signed [DIFF_W-1:0] dx, dz;
  logic                     border;
  logic [ABS_W-1:0]         ax_d, az_d, ax_q, az_q;
  side_t                    sa_d, sa_q, sb_q, sc_q;
  logic [SQ_W-1:0]          sqx_q, sqz_q;
  logic [SUM_W-1:0]         s_q;
  logic [LIM_W-1:0]         limx_q, limz_q;
  logic                     va_q, vb_q, vc_q;

  always_comb begin
    dx = DIFF_W'(hl_i) - DIFF_W'(hr_i);
    dz = DIFF_W'(hb_i) - DIFF_W'(ha_i);
    border = (row_i == '0) || (col_i == '0) ||
             ({1'b0, row_i} + CFG_GW'(1) >= rows_i) ||
             ({1'b0, col_i} + CFG_GW'(1) >= cols_i);
    // Border points take zero slopes, which yields a straight-up normal.
    ax_d = border ? '0 : ABS_W'(dx[DIFF_W-1] ? -dx : dx);
    az_d = border ? '0 : ABS_W'(dz[DIFF_W-1] ? -dz : dz);
    sa_d.hc = hc_i;
    sa_d.sx = !border && dx[DIFF_W-1];
    sa_d.sz = !border && dz[DIFF_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= v_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= ax_d;
      az_q   <= az_d;
      sa_q   <= sa_d;
      sqx_q  <= ax_q * ax_q;
      sqz_q  <= az_q * az_q;
      sb_q   <= sa_q;
      s_q    <= SUM_W'(sqx_q) + SUM_W'(sqz_q) + SUM_ONE;
      limx_q <= LIM_W'(sqx_q) << 28;
      limz_q <= LIM_W'(sqz_q) << 28;
      sc_q   <= sb_q;
    end
  end

  assign v_o = vc_q;
  assign s_o = s_q;
  assign lim_o[LANE_X] = limx_q;
  assign lim_o[LANE_Y] = LIM_Y;
  assign lim_o[LANE_Z] = limz_q;
  assign side_o = sc_q;

endmodule

@@ hdl/tvn_isqrt.sv @@
// Pipelined bit-by-bit search for the three normal magnitudes, one bit per stage.
// Uses tvn_pkg; keeps q*q*s and q*s so each stage needs only adds and a compare.
module tvn_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      v_i,
  input  logic [tvn_pkg::SUM_W-1:0] s_i,
  input  logic [tvn_pkg::LIM_W-1:0] lim_i [tvn_pkg::LANES],
  input  tvn_pkg::side_t            side_i,
  output logic                      v_o,
  output logic [tvn_pkg::NRM_W-1:0] q_o [tvn_pkg::LANES],
  output tvn_pkg::side_t            side_o
);
  import tvn_pkg::*;

  logic             v_q    [SQRT_STEPS];
  logic [SUM_W-1:0] s_q    [SQRT_STEPS];
  side_t            side_q [SQRT_STEPS];
  logic [LIM_W-1:0] lim_q  [SQRT_STEPS][LANES];
  logic [ACC_W-1:0] p_q    [SQRT_STEPS][LANES];
  logic [ACC_W-1:0] r_q    [SQRT_STEPS][LANES];
  logic [NRM_W-1:0] q_q    [SQRT_STEPS][LANES];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int K = SQRT_STEPS - 1 - j;
    logic             v_in;
    logic [SUM_W-1:0] s_in;
    side_t            side_in;
    logic [LIM_W-1:0] lim_in [LANES];
    logic [ACC_W-1:0] p_in [LANES], r_in [LANES], cand [LANES];
    logic [NRM_W-1:0] q_in [LANES];
    logic             take [LANES];

    if (j == 0) begin : g_first
      assign v_in = v_i;
      assign s_in = s_i;
      assign side_in = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign lim_in[l] = lim_i[l];
        assign p_in[l] = '0;
        assign r_in[l] = '0;
        assign q_in[l] = '0;
      end
    end else begin : g_next
      assign v_in = v_q[j-1];
      assign s_in = s_q[j-1];
      assign side_in = side_q[j-1];
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign lim_in[l] = lim_q[j-1][l];
        assign p_in[l] = p_q[j-1][l];
        assign r_in[l] = r_q[j-1][l];
        assign q_in[l] = q_q[j-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        // (q + 2^K)^2 * s = q^2 s + 2^(K+1) q s + 2^(2K) s
        cand[l] = p_in[l] + (r_in[l] << (K + 1)) + (ACC_W'(s_in) << (2 * K));
        take[l] = cand[l] <= ACC_W'(lim_in[l]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[j]    <= s_in;
        side_q[j] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          lim_q[j][l] <= lim_in[l];
          p_q[j][l]   <= take[l] ? cand[l] : p_in[l];
          r_q[j][l]   <= take[l] ? r_in[l] + (ACC_W'(s_in) << K) : r_in[l];
          q_q[j][l]   <= take[l] ? q_in[l] | (NRM_W'(1) << K) : q_in[l];
        end
      end
    end
  end

  assign v_o = v_q[SQRT_STEPS-1];
  assign side_o = side_q[SQRT_STEPS-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign q_o[l] = q_q[SQRT_STEPS-1][l];
  end

endmodule

@@ hdl/tvn_texdiv.sv @@
// Pipelined restoring divider for both texture coordinates, one quotient bit per stage.
// Uses tvn_pkg.
module tvn_texdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       v_i,
  input  logic [tvn_pkg::IDX_W-1:0]  col_i,
  input  logic [tvn_pkg::IDX_W-1:0]  row_i,
  input  logic [tvn_pkg::CFG_TW-1:0] ts_i,
  output logic                       v_o,
  output logic [tvn_pkg::IDX_W-1:0]  col_o,
  output logic [tvn_pkg::IDX_W-1:0]  row_o,
  output logic [tvn_pkg::TEX_W-1:0]  u_o,
  output logic [tvn_pkg::TEX_W-1:0]  v_tex_o
);
  import tvn_pkg::*;

  localparam int NL = 2;  // lane 0: column, lane 1: row

  logic              v_q   [DIV_STEPS];
  logic [CFG_TW-1:0] d_q   [DIV_STEPS];
  logic [TEX_W-1:0]  num_q [DIV_STEPS][NL];
  logic [TEX_W-1:0]  quo_q [DIV_STEPS][NL];
  logic [CFG_TW-1:0] rem_q [DIV_STEPS][NL];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int I = DIV_STEPS - 1 - j;
    logic              v_in;
    logic [CFG_TW-1:0] d_in;
    logic [TEX_W-1:0]  num_in [NL], quo_in [NL];
    logic [CFG_TW-1:0] rem_in [NL], rem_nx [NL];
    logic [CFG_TW:0]   t [NL];
    logic              ge [NL];

    if (j == 0) begin : g_first
      assign v_in = v_i;
      assign d_in = ts_i;
      assign num_in[0] = {col_i, 8'd0};
      assign num_in[1] = {row_i, 8'd0};
      for (genvar l = 0; l < NL; l++) begin : g_l
        assign quo_in[l] = '0;
        assign rem_in[l] = '0;
      end
    end else begin : g_next
      assign v_in = v_q[j-1];
      assign d_in = d_q[j-1];
      for (genvar l = 0; l < NL; l++) begin : g_l
        assign num_in[l] = num_q[j-1][l];
        assign quo_in[l] = quo_q[j-1][l];
        assign rem_in[l] = rem_q[j-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        t[l]      = {rem_in[l], num_in[l][I]};
        ge[l]     = t[l] >= {1'b0, d_in};
        rem_nx[l] = ge[l] ? CFG_TW'(t[l] - {1'b0, d_in}) : t[l][CFG_TW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[j] <= d_in;
        for (int l = 0; l < NL; l++) begin
          num_q[j][l] <= num_in[l];
          rem_q[j][l] <= rem_nx[l];
          quo_q[j][l] <= ge[l] ? quo_in[l] | (TEX_W'(1) << I) : quo_in[l];
        end
      end
    end
  end

  assign v_o     = v_q[DIV_STEPS-1];
  assign col_o   = num_q[DIV_STEPS-1][0][TEX_W-1:8];
  assign row_o   = num_q[DIV_STEPS-1][1][TEX_W-1:8];
  assign u_o     = quo_q[DIV_STEPS-1][0];
  assign v_tex_o = quo_q[DIV_STEPS-1][1];

endmodule

@@ hdl/terrain_vertex_normal_generator.sv @@
// Top level of the terrain vertex normal generator: stream ports, APB registers.
// Uses tvn_pkg, tvn_front, tvn_isqrt and tvn_texdiv.
//
// Usage:
//   One request transaction on the s_axis group carries a grid point (row,
//   column) and five heights; one vertex transaction leaves on m_axis for each.
//   The vertex holds position, a unit normal in Q1.14 and texture coordinates.
//   Border points (first/last row or column, or beyond) get a straight-up normal.
// Pipeline and throughput:
//   A request accepted on s_axis passes one input register, three front stages
//   (difference, square, sum), fifteen normal search stages that run beside an
//   eighteen stage texture divider, and the output register on its way to
//   m_axis. One transaction per cycle is sustained while m_axis does not stall.
// Stalls:
//   The whole pipeline advances together whenever the output register is empty
//   or being taken; while m_axis_tready is low with a pending vertex, every stage
//   holds and s_axis_tready drops, so nothing is lost or repeated.
// Reset:
//   rst_ni clears all valid bits and sets the grid to 1024 columns by 1024
//   rows and the tile size to 16. Write the registers only while the pipeline
//   is empty.
module terrain_vertex_normal_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [9:0] row, [19:10] col, [35:20] height_center, [51:36] height_left,
  // [67:52] height_right, [83:68] height_above, [99:84] height_below, zero pad
  input  logic [103:0] s_axis_tdata,
  // Vertex stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [9:0] pos_x_halves, [25:10] pos_y, [36:26] pos_z_halves, [52:37] normal_x,
  // [67:53] normal_y, [83:68] normal_z, [101:84] tex_u, [119:102] tex_v
  output logic [119:0] m_axis_tdata
);
  import tvn_pkg::*;

  logic [CFG_GW-1:0] cols_q, rows_q;
  logic [CFG_TW-1:0] tile_q, ts;
  logic              wr;
  logic              en;

  // Input register
  logic                    in_v_q;
  logic [IDX_W-1:0]        row_q, col_q;
  logic signed [HGT_W-1:0] hc_q, hl_q, hr_q, ha_q, hb_q;

  logic             f_v;
  logic [SUM_W-1:0] f_s;
  logic [LIM_W-1:0] f_lim [LANES];
  side_t            f_side;

  logic             q_v;
  logic [NRM_W-1:0] q_mag [LANES];
  side_t            q_side;

  logic             d_v;
  logic [IDX_W-1:0] d_col, d_row;
  logic [TEX_W-1:0] d_u, d_vt;

  logic               out_v_q;
  logic [119:0]       out_q;
  logic signed [15:0] nx, nz;
  logic [10:0]        pz;

  // ---------------- configuration registers ----------------
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_GW'(1024);
      rows_q <= CFG_GW'(1024);
      tile_q <= CFG_TW'(16);
    end else if (wr) begin
      case (paddr[3:2])
        REG_COLS: cols_q <= pwdata[CFG_GW-1:0];
        REG_ROWS: rows_q <= pwdata[CFG_GW-1:0];
        REG_TILE: tile_q <= pwdata[CFG_TW-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLS: prdata = 32'(cols_q);
      REG_ROWS: prdata = 32'(rows_q);
      REG_TILE: prdata = 32'(tile_q);
      default:  prdata = '0;
    endcase
  end

  // A tile size of zero divides as one
  assign ts = (tile_q == '0) ? CFG_TW'(1) : tile_q;

  // ---------------- pipeline advance ----------------
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      row_q <= s_axis_tdata[9:0];
      col_q <= s_axis_tdata[19:10];
      hc_q  <= s_axis_tdata[35:20];
      hl_q  <= s_axis_tdata[51:36];
      hr_q  <= s_axis_tdata[67:52];
      ha_q  <= s_axis_tdata[83:68];
      hb_q  <= s_axis_tdata[99:84];
    end
  end

  tvn_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (in_v_q),
    .row_i  (row_q),
    .col_i  (col_q),
    .hc_i   (hc_q),
    .hl_i   (hl_q),
    .hr_i   (hr_q),
    .ha_i   (ha_q),
    .hb_i   (hb_q),
    .cols_i (cols_q),
    .rows_i (rows_q),
    .v_o    (f_v),
    .s_o    (f_s),
    .lim_o  (f_lim),
    .side_o (f_side)
  );

  tvn_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (f_v),
    .s_i    (f_s),
    .lim_i  (f_lim),
    .side_i (f_side),
    .v_o    (q_v),
    .q_o    (q_mag),
    .side_o (q_side)
  );

  // Same depth as front plus search, so both halves of a vertex meet here
  tvn_texdiv u_texdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .v_i     (in_v_q),
    .col_i   (col_q),
    .row_i   (row_q),
    .ts_i    (ts),
    .v_o     (d_v),
    .col_o   (d_col),
    .row_o   (d_row),
    .u_o     (d_u),
    .v_tex_o (d_vt)
  );

  // ---------------- output register ----------------
  always_comb begin
    nx = q_side.sx ? -$signed({1'b0, q_mag[LANE_X]}) : $signed({1'b0, q_mag[LANE_X]});
    nz = q_side.sz ? -$signed({1'b0, q_mag[LANE_Z]}) : $signed({1'b0, q_mag[LANE_Z]});
    pz = 11'd0 - {1'b0, d_row};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= q_v && d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {d_vt, d_u, nz, q_mag[LANE_Y], nx, pz, q_side.hc, d_col};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ hdl/tvn_checker.sv @@
// Port-level checks for the terrain vertex normal generator, bound to the top level.
// Uses no package; sees only the top-level ports.
module tvn_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         pready,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);

  // Hold a stalled vertex
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled vertex changed");

  // Requests are refused only while a vertex waits downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // A full-height normal only comes from a flat point
  a_flat_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[67:53] == 15'd16384 |->
      m_axis_tdata[52:37] == 16'd0 && m_axis_tdata[83:68] == 16'd0)
    else $error("vertical normal with tilt");

  a_ny_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[67:53] <= 15'd16384 && pready)
    else $error("normal_y out of range");

endmodule

bind terrain_vertex_normal_generator tvn_checker u_tvn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
